// ----- hw/rtl/packed_int_array_access_core_assert.svh -----
// ----------------------------------------------------------------------------
// Packed integer array assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKED_INT_ARRAY_ACCESS_CORE_ASSERT_SVH
`define PACKED_INT_ARRAY_ACCESS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge while reset is released.
`define PKIA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define PKIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PKIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PKIA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/pkia_pkg.sv -----
// ----------------------------------------------------------------------------
// Packed integer array package
// Sizes, codes and beat types shared by the packed integer array core.
// ----------------------------------------------------------------------------
package pkia_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int STORE_WORDS  = 1026;

  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int EW_W     = 6;
  localparam int CFG_W    = 11;
  localparam int BITPOS_W = INDEX_W + EW_W;
  localparam int WORD_W   = BITPOS_W - 5;

  // Even words live in one bank and odd words in the other.
  localparam int BANK_ROWS = (STORE_WORDS + 1) / 2;
  localparam int ROW_W     = $clog2(BANK_ROWS);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } pkia_op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_INDEX = 2'd1,
    STATUS_TOO_WIDE  = 2'd2
  } pkia_status_e;

  typedef enum logic {
    CFG_ELEMENT_COUNT = 1'b0,
    CFG_ELEMENT_WIDTH = 1'b1
  } pkia_cfg_e;

  typedef struct packed {
    pkia_op_e             operation;
    logic [INDEX_W-1:0]   index;
    logic [VALUE_W-1:0]   value;
  } pkia_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   read_data;
    pkia_status_e         status;
  } pkia_rsp_t;

endpackage

// ----- hw/rtl/pkia_ram.sv -----
// ----------------------------------------------------------------------------
// Packed integer array word RAM
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module pkia_ram #(
  parameter int DEPTH = 513,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/packed_int_array_access_core.sv -----
// ----------------------------------------------------------------------------
// Packed integer array access core
// Reads or writes one fixed-width element of a bit-packed word store.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Beat
// request   in         start_i high, busy_o low     req_i
// result    out        done_o for one cycle         rsp_o
// config    in         cfg_valid_i and cfg_ready_o  cfg_index_i, cfg_data_i
//
// A request passes through four steps: accept, address and checks, word read,
// then merge with write-back. A new request is taken while busy_o is low.
// After reset a clearing pass writes zeros over all 513 bank rows, one row
// per cycle, with busy_o high; configuration writes are taken throughout.
// The result has no back-pressure and is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "packed_int_array_access_core_assert.svh"

module packed_int_array_access_core
  import pkia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  pkia_req_t        req_i,
  output logic             done_o,
  output pkia_rsp_t        rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  pkia_cfg_e        cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_RD,
    S_MOD
  } state_e;

  state_e                state_q;
  logic [ROW_W-1:0]      clr_cnt_q;
  pkia_req_t             req_q;
  logic                  done_q;
  pkia_rsp_t             rsp_q;

  logic [COUNT_W-1:0]    cfg_count_q;
  logic [EW_W-1:0]       cfg_width_q;

  logic                  word_lsb_q;
  logic [ROW_W-1:0]      even_addr_q;
  logic [ROW_W-1:0]      odd_addr_q;
  logic [5:0]            shift_q;
  logic [VALUE_W-1:0]    fmask_q;
  pkia_status_e          status_q;
  logic [63:0]           joined_q;

  logic [EW_W-1:0]       width_eff;
  logic [COUNT_W-1:0]    count_eff;
  logic [BITPOS_W-1:0]   bitpos;
  logic [WORD_W-1:0]     word;
  logic [6:0]            field_end;
  logic [VALUE_W:0]      mask_wide;
  logic [VALUE_W-1:0]    fmask;
  logic                  bad_index;
  logic                  too_wide;
  logic [ROW_W-1:0]      even_raddr;
  logic [ROW_W-1:0]      odd_raddr;

  logic [VALUE_W-1:0]    even_rdata;
  logic [VALUE_W-1:0]    odd_rdata;
  logic [63:0]           field_mask;
  logic [63:0]           merged;
  logic [VALUE_W-1:0]    rd_field;
  logic                  do_write;
  logic                  even_we;
  logic                  odd_we;
  logic [ROW_W-1:0]      even_waddr;
  logic [ROW_W-1:0]      odd_waddr;
  logic [VALUE_W-1:0]    even_wdata;
  logic [VALUE_W-1:0]    odd_wdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= '0;
      cfg_width_q <= EW_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ELEMENT_COUNT: cfg_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_ELEMENT_WIDTH: cfg_width_q <= cfg_data_i[EW_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (cfg_width_q == '0) begin
      width_eff = EW_W'(1);
    end else if (cfg_width_q > EW_W'(VALUE_W)) begin
      width_eff = EW_W'(VALUE_W);
    end else begin
      width_eff = cfg_width_q;
    end
    count_eff = (cfg_count_q > COUNT_W'(MAX_ELEMENTS)) ? COUNT_W'(MAX_ELEMENTS) : cfg_count_q;

    bitpos    = BITPOS_W'(req_q.index) * BITPOS_W'(width_eff);
    word      = bitpos[BITPOS_W-1:5];
    field_end = 7'(bitpos[4:0]) + 7'(width_eff);
    mask_wide = ((VALUE_W+1)'(1) << width_eff) - (VALUE_W+1)'(1);
    fmask     = mask_wide[VALUE_W-1:0];

    bad_index = (COUNT_W'(req_q.index) >= count_eff) || (int'(word) + 1 >= STORE_WORDS);
    too_wide  = (req_q.value & ~fmask) != '0;

    odd_raddr  = ROW_W'(word >> 1);
    even_raddr = ROW_W'((word >> 1) + WORD_W'(word[0]));
  end

  pkia_ram #(
    .DEPTH (BANK_ROWS),
    .WIDTH (VALUE_W)
  ) u_even_bank (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (even_waddr),
    .wdata_i (even_wdata),
    .raddr_i (even_raddr),
    .rdata_o (even_rdata)
  );

  pkia_ram #(
    .DEPTH (BANK_ROWS),
    .WIDTH (VALUE_W)
  ) u_odd_bank (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (odd_waddr),
    .wdata_i (odd_wdata),
    .raddr_i (odd_raddr),
    .rdata_o (odd_rdata)
  );

  always_comb begin
    field_mask = 64'(fmask_q) << shift_q;
    merged     = (joined_q & ~field_mask) | (64'(req_q.value) << shift_q);
    rd_field   = VALUE_W'(joined_q >> shift_q) & fmask_q;
    do_write   = (state_q == S_MOD) && (req_q.operation == OP_WRITE) &&
                 (status_q == STATUS_OK);

    if (state_q == S_CLEAR) begin
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_waddr = clr_cnt_q;
      odd_waddr  = clr_cnt_q;
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      even_we    = do_write;
      odd_we     = do_write;
      even_waddr = even_addr_q;
      odd_waddr  = odd_addr_q;
      even_wdata = word_lsb_q ? merged[31:0] : merged[63:32];
      odd_wdata  = word_lsb_q ? merged[63:32] : merged[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (clr_cnt_q == ROW_W'(BANK_ROWS - 1)) begin
            state_q <= S_IDLE;
          end
          clr_cnt_q <= clr_cnt_q + ROW_W'(1);
        end
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_i;
    end
    if (state_q == S_CALC) begin
      word_lsb_q  <= word[0];
      even_addr_q <= even_raddr;
      odd_addr_q  <= odd_raddr;
      shift_q     <= 6'(7'd64 - field_end);
      fmask_q     <= fmask;
      if (bad_index) begin
        status_q <= STATUS_BAD_INDEX;
      end else if (req_q.operation == OP_WRITE && too_wide) begin
        status_q <= STATUS_TOO_WIDE;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (state_q == S_RD) begin
      joined_q <= word_lsb_q ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};
    end
    if (state_q == S_MOD) begin
      rsp_q.status <= status_q;
      if (status_q == STATUS_OK && req_q.operation == OP_READ) begin
        rsp_q.read_data <= rd_field;
      end else begin
        rsp_q.read_data <= '0;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `PKIA_ASSERT(a_done_after_merge, clk_i, rst_ni, done_o |-> $past(state_q == S_MOD), "result without merge step")
  `PKIA_ASSERT(a_write_only_when_owned, clk_i, rst_ni, (even_we || odd_we) |-> (state_q == S_MOD || state_q == S_CLEAR), "bank write outside merge or clear")
  `PKIA_ASSERT(a_error_zero_data, clk_i, rst_ni, (done_o && rsp_o.status != STATUS_OK) |-> (rsp_o.read_data == '0), "error result carries data")
  `PKIA_ASSERT(a_accept_starts_calc, clk_i, rst_ni, (start_i && !busy_o) |=> (state_q == S_CALC), "accepted beat not processed")
  `PKIA_ASSERT_ALWAYS(a_reset_clears_done, clk_i, !rst_ni |-> !done_o, "result strobe during reset")

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Packed integer array core testbench
// Sends read and write requests to the packed element store under a series
// of element count and width settings, predicts every result from a private
// copy of the word store and checks each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pkia_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  pkia_req_t        req_i;
  logic             done_o;
  pkia_rsp_t        rsp_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  pkia_cfg_e        cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  logic [VALUE_W-1:0] store_words [STORE_WORDS];
  logic [COUNT_W-1:0] model_count;
  logic [EW_W-1:0]    model_width;

  pkia_req_t access_queue[$];
  pkia_rsp_t predicted_results[$];
  bit        access_taken;
  bit        no_gaps;
  int        gap_left;
  int        errors;

  packed_int_array_access_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic int unsigned cur_width();
    if (model_width == 0) return 1;
    if (model_width > 32) return 32;
    return 32'(model_width);
  endfunction

  function automatic int unsigned cur_count();
    if (model_count > MAX_ELEMENTS) return MAX_ELEMENTS;
    return 32'(model_count);
  endfunction

  function automatic pkia_rsp_t access_store(pkia_req_t r);
    pkia_rsp_t   rsp;
    int unsigned w;
    int unsigned bitpos;
    int unsigned word;
    int unsigned shift;
    logic [63:0] mask;
    logic [63:0] joined;
    logic [63:0] val;
    w      = cur_width();
    mask   = (w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 64'd1);
    bitpos = r.index * w;
    word   = bitpos >> 5;
    val    = {32'd0, r.value};
    rsp.read_data = '0;
    rsp.status    = STATUS_OK;
    if (r.index >= cur_count() || word + 1 >= STORE_WORDS) begin
      rsp.status = STATUS_BAD_INDEX;
    end else begin
      shift  = 64 - ((bitpos & 31) + w);
      joined = {store_words[word], store_words[word+1]};
      if (r.operation == OP_READ) begin
        rsp.read_data = 32'((joined >> shift) & mask);
      end else if (val > mask) begin
        rsp.status = STATUS_TOO_WIDE;
      end else begin
        joined = (joined & ~(mask << shift)) | (val << shift);
        store_words[word]   = joined[63:32];
        store_words[word+1] = joined[31:0];
      end
    end
    return rsp;
  endfunction

  function automatic pkia_req_t make_access(int unsigned cnt, int unsigned w);
    pkia_req_t   r;
    logic [63:0] mask;
    int unsigned pick;
    int unsigned span;
    int unsigned base;
    mask = (w >= 32) ? 64'hFFFF_FFFF : ((64'd1 << w) - 64'd1);
    r.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    pick = $urandom_range(0, 99);
    if (cnt == 0 || pick < 12) begin
      r.index = INDEX_W'($urandom_range(0, 1023));
    end else if (pick < 60) begin
      span = (cnt < 24) ? cnt : 24;
      base = $urandom_range(0, cnt - span);
      r.index = INDEX_W'(base + $urandom_range(0, span - 1));
    end else begin
      r.index = INDEX_W'($urandom_range(0, cnt - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      r.value = $urandom() & mask[31:0];
    end else if (pick < 88) begin
      r.value = mask[31:0] + 32'(w < 32);
    end else if (pick < 94) begin
      r.value = mask[31:0];
    end else begin
      r.value = $urandom();
    end
    return r;
  endfunction

  task automatic queue_access(input pkia_op_e op, input int unsigned idx,
                              input logic [VALUE_W-1:0] val);
    pkia_req_t r;
    r.operation = op;
    r.index     = INDEX_W'(idx);
    r.value     = val;
    access_queue.push_back(r);
  endtask

  task automatic write_reg(input pkia_cfg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ELEMENT_COUNT) begin
      model_count = data[COUNT_W-1:0];
    end else begin
      model_width = data[EW_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (access_queue.size() != 0 || predicted_results.size() != 0 || busy_o)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] width_data,
                           input int n);
    int unsigned cnt;
    int unsigned w;
    wait_idle();
    write_reg(CFG_ELEMENT_COUNT, count);
    write_reg(CFG_ELEMENT_WIDTH, width_data);
    cnt = cur_count();
    w   = cur_width();
    repeat (n) access_queue.push_back(make_access(cnt, w));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("tb: FAIL");
    $finish;
  end

  always @(negedge clk_i) begin : request_driver
    bit can_gap;
    if (access_taken) begin
      access_queue.delete(0);
      access_taken = 1'b0;
      can_gap = 1'b1;
    end else begin
      can_gap = !start_i;
    end
    if (gap_left == 0 && can_gap && !no_gaps && access_queue.size() > 0 &&
        $urandom_range(0, 3) == 0)
      gap_left = $urandom_range(1, 4);
    if (gap_left > 0) begin
      gap_left--;
      start_i <= 1'b0;
    end else if (rst_ni && access_queue.size() > 0) begin
      start_i <= 1'b1;
      req_i   <= access_queue[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    pkia_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (rsp_o.read_data !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, rsp_o.read_data);
            errors++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_o.status);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predicted_results.push_back(access_store(req_i));
        access_taken = 1'b1;
      end
    end
  end

  initial begin
    start_i     = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ELEMENT_COUNT;
    cfg_data_i  = '0;
    errors      = 0;
    gap_left    = 0;
    no_gaps     = 1'b0;
    access_taken = 1'b0;
    foreach (store_words[i]) store_words[i] = '0;
    model_count = '0;
    model_width = 6'd1;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers still at their reset values: every index is rejected.
    queue_access(OP_READ, 0, 32'd0);
    queue_access(OP_WRITE, 1023, 32'd1);

    run_phase(11'd1024, 11'd32, 0);
    queue_access(OP_WRITE, 0, 32'hFFFF_FFFF);
    queue_access(OP_READ, 0, 32'hFFFF_FFFF);
    queue_access(OP_WRITE, 1023, 32'hA5A5_A5A5);
    queue_access(OP_READ, 1023, 32'd0);
    queue_access(OP_READ, 1022, 32'd0);
    queue_access(OP_WRITE, 3, 32'hFFFF_FFFF);
    queue_access(OP_WRITE, 3, 32'h1234_5678);
    queue_access(OP_READ, 3, 32'd0);

    // Count above the limit and a zero width, with old words read in the new layout.
    run_phase(11'd2047, 11'h7C0, 0);
    queue_access(OP_READ, 0, 32'd0);
    queue_access(OP_READ, 32, 32'd0);
    queue_access(OP_WRITE, 1023, 32'd1);
    queue_access(OP_WRITE, 1022, 32'd2);
    queue_access(OP_READ, 1023, 32'd0);

    // A width above 32 behaves as 32.
    run_phase(11'd1, 11'h7FF, 0);
    queue_access(OP_READ, 0, 32'd0);
    queue_access(OP_READ, 1, 32'd0);
    queue_access(OP_WRITE, 0, 32'd0);

    // Elements that straddle two words, and the index check made before the value check.
    run_phase(11'd200, 11'd5, 0);
    queue_access(OP_WRITE, 6, 32'd31);
    queue_access(OP_READ, 6, 32'd0);
    queue_access(OP_WRITE, 6, 32'd32);
    queue_access(OP_WRITE, 200, 32'd32);
    queue_access(OP_READ, 5, 32'd0);
    queue_access(OP_READ, 7, 32'd0);

    run_phase(11'd1024, 11'd32, 80);
    run_phase(11'd1024, 11'd1, 80);
    run_phase(11'd48, 11'd5, 50);
    run_phase(11'd2047, 11'd13, 60);
    run_phase(11'd0, 11'd7, 10);
    run_phase(11'd600, 11'd31, 50);
    run_phase(11'd1024, 11'd17, 50);
    run_phase(11'd300, 11'd33, 40);
    run_phase(11'($urandom_range(1, 1024)),
              {5'($urandom()), 6'($urandom_range(1, 32))}, 50);
    wait_idle();
    no_gaps = 1'b1;
    run_phase(11'd1024, 11'd3, 50);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pkia_pkg.sv
hw/rtl/pkia_ram.sv
hw/rtl/packed_int_array_access_core.sv
test/tb.sv
